@@ rtl/core/jds_pkg.sv @@
// Shared types and constants for the joystick deadband scaler.
package jds_pkg;

  localparam int SAMPLE_BITS = 8;
  localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
  localparam int FULL_SCALE  = 100;
  localparam int QUOT_W      = 7;
  localparam int NUM_W       = 15;
  localparam int BAND_W      = 6;
  localparam int THRESH_W    = 7;
  localparam int PCT_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_CENTER  = 2'd0,
    REG_Y_CENTER  = 2'd1,
    REG_DEAD_BAND = 2'd2,
    REG_THRESHOLD = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    DIR_NEUTRAL = 3'd0,
    DIR_LEFT    = 3'd1,
    DIR_RIGHT   = 3'd2,
    DIR_UP      = 3'd3,
    DIR_DOWN    = 3'd4
  } dir_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] x_sample;
    logic [SAMPLE_BITS-1:0] y_sample;
    logic [SAMPLE_BITS-1:0] left_sample;
    logic [SAMPLE_BITS-1:0] right_sample;
  } sample_t;

  typedef struct packed {
    logic signed [PCT_W-1:0] x_percent;
    logic signed [PCT_W-1:0] y_percent;
    dir_t                    direction;
    logic [QUOT_W-1:0]       left_percent;
    logic [QUOT_W-1:0]       right_percent;
  } result_t;

  // What one lane hands to the merge stage.
  typedef struct packed {
    logic              neg;
    logic [QUOT_W-1:0] mag;
  } lane_res_t;

endpackage

@@ rtl/core/jds_lane.sv @@
// One scaling lane: band test, numerator setup and a pipelined restoring divider.
module jds_lane (
  input  logic                                clk,
  input  logic                                en,
  input  logic                                slider,
  input  logic [jds_pkg::SAMPLE_BITS-1:0]     sample,
  input  logic [jds_pkg::SAMPLE_BITS-1:0]     center,
  input  logic [jds_pkg::BAND_W-1:0]          dead_band,
  output jds_pkg::lane_res_t                  res
);

  localparam int SB = jds_pkg::SAMPLE_BITS;
  localparam int NW = jds_pkg::NUM_W;
  localparam int QW = jds_pkg::QUOT_W;

  logic [SB+1:0]  s_ext;
  logic [SB+1:0]  c_ext;
  logic [SB+1:0]  db_ext;
  logic           above;
  logic           below;
  logic [SB-1:0]  diff;
  logic [SB-1:0]  divisor;
  logic           neg_in;
  logic [NW-1:0]  num;

  logic [NW-1:0]  rem [0:QW];
  logic [SB-1:0]  dv  [0:QW];
  logic [QW-1:0]  q   [0:QW];
  logic           ng  [0:QW];

  assign s_ext  = {2'b00, sample};
  assign c_ext  = {2'b00, center};
  assign db_ext = {{(SB+2-jds_pkg::BAND_W){1'b0}}, dead_band};
  // Full-width compares so a band running past either end never wraps.
  assign above  = s_ext > (c_ext + db_ext);
  assign below  = (s_ext + db_ext) < c_ext;

  always_comb begin
    if (slider) begin
      diff    = sample;
      divisor = SB'(jds_pkg::SAMPLE_MAX);
      neg_in  = 1'b0;
    end else if (above) begin
      diff    = sample - center;
      divisor = SB'(jds_pkg::SAMPLE_MAX) - center;
      neg_in  = 1'b0;
    end else if (below) begin
      diff    = center - sample;
      divisor = center;
      neg_in  = 1'b1;
    end else begin
      // Inside the band: a zero numerator yields a zero quotient.
      diff    = '0;
      divisor = SB'(1);
      neg_in  = 1'b0;
    end
  end

  assign num = NW'({{(NW-SB){1'b0}}, diff} * NW'(jds_pkg::FULL_SCALE));

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      dv[0]  <= divisor;
      q[0]   <= '0;
      ng[0]  <= neg_in;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar i = 0; i < QW; i++) begin : g_div
    localparam int K = QW - 1 - i;
    logic [NW:0] sh;
    logic        ge;

    assign sh = {{(NW+1-SB){1'b0}}, dv[i]} << K;
    assign ge = {1'b0, rem[i]} >= sh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? (rem[i] - sh[NW-1:0]) : rem[i];
        dv[i+1]  <= dv[i];
        q[i+1]   <= {q[i][QW-2:0], ge};
        ng[i+1]  <= ng[i];
      end
    end
  end

  assign res.neg = ng[QW];
  assign res.mag = q[QW];

endmodule

@@ rtl/core/jds_merge.sv @@
// Merge stage: signs and clamps the X and Y lane results, picks the direction, holds the result.
module jds_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  jds_pkg::lane_res_t            x_res,
  input  jds_pkg::lane_res_t            y_res,
  input  jds_pkg::lane_res_t            l_res,
  input  jds_pkg::lane_res_t            r_res,
  input  logic [jds_pkg::THRESH_W-1:0]  threshold,
  output logic                          vld,
  output jds_pkg::result_t              data
);

  localparam int QW = jds_pkg::QUOT_W;
  localparam int PW = jds_pkg::PCT_W;

  logic [QW-1:0]     x_mag;
  logic [QW-1:0]     y_mag;
  jds_pkg::dir_t     dir;
  jds_pkg::result_t  data_next;

  assign x_mag = (x_res.mag > QW'(jds_pkg::FULL_SCALE)) ? QW'(jds_pkg::FULL_SCALE) : x_res.mag;
  assign y_mag = (y_res.mag > QW'(jds_pkg::FULL_SCALE)) ? QW'(jds_pkg::FULL_SCALE) : y_res.mag;

  // The dominant axis decides; a tie goes to X.
  always_comb begin
    dir = jds_pkg::DIR_NEUTRAL;
    if (x_mag >= y_mag) begin
      if (x_mag > threshold) begin
        dir = x_res.neg ? jds_pkg::DIR_LEFT : jds_pkg::DIR_RIGHT;
      end
    end else begin
      if (y_mag > threshold) begin
        dir = y_res.neg ? jds_pkg::DIR_DOWN : jds_pkg::DIR_UP;
      end
    end
  end

  always_comb begin
    data_next.x_percent     = x_res.neg ? -$signed({1'b0, x_mag}) : $signed({1'b0, x_mag});
    data_next.y_percent     = y_res.neg ? -$signed({1'b0, y_mag}) : $signed({1'b0, y_mag});
    data_next.direction     = dir;
    data_next.left_percent  = l_res.mag;
    data_next.right_percent = r_res.mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule

@@ rtl/core/joystick_deadband_scaler_unit.sv @@
// Top level of the joystick deadband scaler: config registers, four lanes and the merge stage.
// Each sample set passes the setup register, the divider stages and the merge register in turn.
// Throughput: one sample set per cycle unless the output stalls; each lane's 7-stage
// divider retires one quotient bit per stage and the merge register sits behind it, so the
// pipeline advances whenever the output register is empty or its result is being transferred.
// Reset (rst, synchronous, active high) empties the pipeline and loads the register defaults:
// both centers 128, dead band 3, direction threshold 10.
module joystick_deadband_scaler_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  jds_pkg::sample_t                   sample,
  output logic                               result_valid,
  input  logic                               result_stall,
  output jds_pkg::result_t                   result,
  input  logic                               cfg_write,
  input  logic [jds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jds_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SB     = jds_pkg::SAMPLE_BITS;
  // One setup stage plus one stage per quotient bit.
  localparam int STAGES = jds_pkg::QUOT_W + 1;

  logic [SB-1:0]                  x_center;
  logic [SB-1:0]                  y_center;
  logic [jds_pkg::BAND_W-1:0]     dead_band;
  logic [jds_pkg::THRESH_W-1:0]   direction_threshold;

  logic                           adv;
  logic [STAGES-1:0]              vld;
  jds_pkg::lane_res_t             x_res;
  jds_pkg::lane_res_t             y_res;
  jds_pkg::lane_res_t             l_res;
  jds_pkg::lane_res_t             r_res;

  // Configuration writes. The user must write only while the pipeline is empty; the block does not
  // enforce it, and the lanes read these registers directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_center            <= SB'(128);
      y_center            <= SB'(128);
      dead_band           <= jds_pkg::BAND_W'(3);
      direction_threshold <= jds_pkg::THRESH_W'(10);
    end else if (cfg_write) begin
      case (jds_pkg::cfg_reg_t'(cfg_index))
        jds_pkg::REG_X_CENTER:  x_center            <= cfg_data[SB-1:0];
        jds_pkg::REG_Y_CENTER:  y_center            <= cfg_data[SB-1:0];
        jds_pkg::REG_DEAD_BAND: dead_band           <= cfg_data[jds_pkg::BAND_W-1:0];
        jds_pkg::REG_THRESHOLD: direction_threshold <= cfg_data[jds_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves as one. It holds only when the output register is
  // full and its result is stalled; bubbles simply travel along.
  assign adv          = !result_valid || !result_stall;
  assign sample_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STAGES-2:0], sample_valid};
    end
  end

  // Two joystick lanes measured against their centers, two slider lanes
  // scaled against full scale.
  jds_lane u_lane_x (
    .clk       (clk),
    .en        (adv),
    .slider    (1'b0),
    .sample    (sample.x_sample),
    .center    (x_center),
    .dead_band (dead_band),
    .res       (x_res)
  );

  jds_lane u_lane_y (
    .clk       (clk),
    .en        (adv),
    .slider    (1'b0),
    .sample    (sample.y_sample),
    .center    (y_center),
    .dead_band (dead_band),
    .res       (y_res)
  );

  jds_lane u_lane_l (
    .clk       (clk),
    .en        (adv),
    .slider    (1'b1),
    .sample    (sample.left_sample),
    .center    (x_center),
    .dead_band (dead_band),
    .res       (l_res)
  );

  jds_lane u_lane_r (
    .clk       (clk),
    .en        (adv),
    .slider    (1'b1),
    .sample    (sample.right_sample),
    .center    (y_center),
    .dead_band (dead_band),
    .res       (r_res)
  );

  // The merge stage owns the output register and its valid flag.
  jds_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_vld    (vld[STAGES-1]),
    .x_res     (x_res),
    .y_res     (y_res),
    .l_res     (l_res),
    .r_res     (r_res),
    .threshold (direction_threshold),
    .vld       (result_valid),
    .data      (result)
  );

endmodule

@@ rtl/core/jds_checker.sv @@
// Port-level checker for the joystick deadband scaler, bound to the top level.
module jds_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               result_valid,
  input  logic                               result_stall,
  input  jds_pkg::result_t                   result
);

  // A stalled result stays offered and unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  // A reported left direction agrees with the sign of X.
  a_dir_x_sign: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.direction == jds_pkg::DIR_LEFT) |-> result.x_percent < 0)
    else $error("left direction with non-negative X");

  a_dir_y_sign: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.direction == jds_pkg::DIR_UP) |-> result.y_percent > 0)
    else $error("up direction with non-positive Y");

  // The scaled X, left and right values stay within full travel.
  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.x_percent >= -100 && result.x_percent <= 100 &&
                     result.left_percent <= 100 && result.right_percent <= 100)
    else $error("scaled value out of range");

endmodule

bind joystick_deadband_scaler_unit jds_checker u_jds_checker (.*);
